/* design/scfr_pkg.sv */
package scfr_pkg;

  // Frame buffer geometry
  localparam int FRAME_BUFFER_BYTES = 64;
  localparam int BUF_AW             = $clog2(FRAME_BUFFER_BYTES);

  // Frame layout: two headers, source, type, length, payload, checksum, end mark
  localparam logic [6:0] HDR_BYTES      = 7'd5;
  localparam logic [6:0] FIXED_BYTES    = 7'd7;
  localparam logic [7:0] END_MARK       = 8'hFF;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [2:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [2:0] CFG_SOURCE_CODE   = 3'd2;
  localparam logic [2:0] CFG_HIGHEST_TYPE  = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN       = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT       = 3'd5;
  localparam logic [2:0] CFG_LEN_TABLE     = 3'd6;

  // Configuration reset values
  localparam logic [7:0]  RST_HEADER_FIRST  = 8'hA5;
  localparam logic [7:0]  RST_HEADER_SECOND = 8'h5A;
  localparam logic [7:0]  RST_SOURCE_CODE   = 8'h00;
  localparam logic [2:0]  RST_HIGHEST_TYPE  = 3'd7;
  localparam logic [5:0]  RST_MAX_LEN       = 6'd32;
  localparam logic [15:0] RST_TIMEOUT       = 16'd100;
  localparam logic [63:0] RST_LEN_TABLE     = 64'd0;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_SRC  = 3'd2,
    PH_TYPE = 3'd3,
    PH_LEN  = 3'd4,
    PH_BODY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_UNKNOWN   = 2'd3
  } frame_status_t;

  // Frame end report from parser to emitter
  typedef struct packed {
    logic          valid;
    frame_status_t status;
    logic [2:0]    ftype;
    logic [5:0]    len;
  } frame_event_t;

  // Emitter condition seen by the parser
  typedef struct packed {
    logic ready;
    logic busy;
  } emit_status_t;

  // One result item
  typedef struct packed {
    frame_status_t status;
    logic [2:0]    ftype;
    logic [5:0]    len;
    logic [5:0]    idx;
    logic [7:0]    data;
    logic          last;
  } result_t;

endpackage

/* design/scfr_ram.sv */
module scfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/scfr_parser.sv */
module scfr_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  input  logic                        s_tuser,
  input  logic                        cfg_valid,
  input  logic [2:0]                  cfg_index,
  input  logic [63:0]                 cfg_data,
  input  scfr_pkg::emit_status_t      emit,
  output scfr_pkg::frame_event_t      event_o,
  output logic                        ram_we,
  output logic [scfr_pkg::BUF_AW-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata
);
  import scfr_pkg::*;

  // Configuration registers
  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  source_code;
  logic [2:0]  highest_type;
  logic [5:0]  max_payload_len;
  logic [15:0] timeout_ticks;
  logic [63:0] len_table;

  // Input register
  logic       in_valid;
  logic       in_tick;
  logic [7:0] in_byte;

  // Parse state
  phase_t      phase, phase_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [2:0]  held_type, held_type_next;
  logic [5:0]  held_len, held_len_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [7:0]  prev_byte, prev_byte_next;

  logic        byte_item;
  logic        timed_out;
  logic        overflow;
  logic        body_write;
  logic [6:0]  count_inc;
  logic        frame_end;
  logic        stall;
  logic        consume;
  logic [7:0]  want_len;

  // Shared decode of the held item
  assign byte_item  = in_valid && !in_tick;
  assign timed_out  = elapsed_ms > timeout_ticks;
  assign overflow   = byte_count >= 7'(FRAME_BUFFER_BYTES);
  assign body_write = byte_item && (phase == PH_BODY) && !timed_out && !overflow;
  assign count_inc  = byte_count + 7'd1;
  assign frame_end  = body_write && (count_inc >= ({1'b0, held_len} + FIXED_BYTES));
  assign want_len   = len_table[{held_type, 3'b000} +: 8];

  // Hold body bytes while a run still reads the buffer, and a frame's last byte until the emitter is idle
  assign stall    = body_write && (emit.busy || (frame_end && !emit.ready));
  assign consume  = in_valid && !stall;
  assign s_tready = !in_valid || consume;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= RST_HEADER_FIRST;
      header_second   <= RST_HEADER_SECOND;
      source_code     <= RST_SOURCE_CODE;
      highest_type    <= RST_HIGHEST_TYPE;
      max_payload_len <= RST_MAX_LEN;
      timeout_ticks   <= RST_TIMEOUT;
      len_table       <= RST_LEN_TABLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  header_first    <= cfg_data[7:0];
        CFG_HEADER_SECOND: header_second   <= cfg_data[7:0];
        CFG_SOURCE_CODE:   source_code     <= cfg_data[7:0];
        CFG_HIGHEST_TYPE:  highest_type    <= cfg_data[2:0];
        CFG_MAX_LEN:       max_payload_len <= cfg_data[5:0];
        CFG_TIMEOUT:       timeout_ticks   <= cfg_data[15:0];
        CFG_LEN_TABLE:     len_table       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (consume && !in_tick) begin
      case (phase)
        PH_HDR1: begin
          if (in_byte == header_first) begin
            phase_next = PH_HDR2;
          end
        end
        PH_HDR2: begin
          phase_next = (in_byte == header_second) ? PH_SRC : PH_HDR1;
        end
        PH_SRC: begin
          phase_next = (in_byte == source_code) ? PH_TYPE : PH_HDR1;
        end
        PH_TYPE: begin
          phase_next = (in_byte > {5'd0, highest_type}) ? PH_HDR1 : PH_LEN;
        end
        PH_LEN: begin
          phase_next = (in_byte > {2'd0, max_payload_len}) ? PH_HDR1 : PH_BODY;
        end
        PH_BODY: begin
          if (!body_write || frame_end) begin
            phase_next = PH_HDR1;
          end
        end
        default: phase_next = PH_HDR1;
      endcase
    end
  end

  // Datapath updates, buffer write and frame end report
  always_comb begin
    byte_count_next  = byte_count;
    held_type_next   = held_type;
    held_len_next    = held_len;
    running_sum_next = running_sum;
    elapsed_ms_next  = elapsed_ms;
    prev_byte_next   = prev_byte;
    ram_we           = 1'b0;
    ram_waddr        = byte_count[BUF_AW-1:0];
    ram_wdata        = in_byte;
    event_o          = '0;
    if (consume && in_tick) begin
      if (elapsed_ms != ELAPSED_MAX) begin
        elapsed_ms_next = elapsed_ms + 16'd1;
      end
    end else if (consume) begin
      case (phase)
        PH_HDR1: begin
          if (in_byte == header_first) begin
            elapsed_ms_next = '0;
            byte_count_next = '0;
          end
        end
        PH_HDR2: begin
          if (in_byte == header_second) begin
            byte_count_next  = 7'd2;
            running_sum_next = '0;
          end
        end
        PH_SRC: begin
          if (in_byte == source_code) begin
            byte_count_next  = count_inc;
            running_sum_next = running_sum + in_byte;
          end else begin
            byte_count_next = '0;
          end
        end
        PH_TYPE: begin
          if (in_byte <= {5'd0, highest_type}) begin
            byte_count_next  = count_inc;
            running_sum_next = running_sum + in_byte;
            held_type_next   = in_byte[2:0];
          end
        end
        PH_LEN: begin
          if (in_byte <= {2'd0, max_payload_len}) begin
            byte_count_next  = count_inc;
            running_sum_next = running_sum + in_byte;
            held_len_next    = in_byte[5:0];
          end else begin
            byte_count_next = '0;
          end
        end
        PH_BODY: begin
          if (!body_write) begin
            byte_count_next = '0;
          end else begin
            // Sum covers source, type, length and payload bytes, not checksum or end mark
            if (byte_count < (HDR_BYTES + {1'b0, held_len})) begin
              running_sum_next = running_sum + in_byte;
            end
            ram_we          = 1'b1;
            prev_byte_next  = in_byte;
            byte_count_next = frame_end ? 7'd0 : count_inc;
            if (frame_end) begin
              event_o.valid = 1'b1;
              event_o.ftype = held_type;
              event_o.len   = held_len;
              if (prev_byte != running_sum_next || in_byte != END_MARK) begin
                event_o.status = ST_BAD_CHECK;
              end else if (want_len == 8'd0) begin
                event_o.status = ST_UNKNOWN;
              end else if (want_len != {2'd0, held_len}) begin
                event_o.status = ST_BAD_LEN;
              end else begin
                event_o.status = ST_GOOD;
              end
            end
          end
        end
        default: byte_count_next = '0;
      endcase
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      byte_count  <= '0;
      held_type   <= '0;
      held_len    <= '0;
      running_sum <= '0;
      elapsed_ms  <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      held_type   <= held_type_next;
      held_len    <= held_len_next;
      running_sum <= running_sum_next;
      elapsed_ms  <= elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    prev_byte <= prev_byte_next;
  end

endmodule

/* design/scfr_emitter.sv */
module scfr_emitter (
  input  logic                        clk,
  input  logic                        rst,
  input  scfr_pkg::frame_event_t      event_i,
  output scfr_pkg::emit_status_t      emit,
  output logic                        ram_re,
  output logic [scfr_pkg::BUF_AW-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scfr_pkg::result_t           out_item
);
  import scfr_pkg::*;

  // Run sequencer
  logic       run_active;
  logic [5:0] run_idx;
  logic [2:0] run_type;
  logic [5:0] run_len;

  // Read stage: buffer data for rd_idx sits on ram_rdata
  logic       rd_valid;
  logic [5:0] rd_idx;
  logic       rd_last;

  logic       out_load;
  logic       rd_move;
  logic       issue;
  logic       issue_last;

  assign out_load   = !out_valid || out_ready;
  assign rd_move    = rd_valid && out_load;
  assign issue      = run_active && (!rd_valid || out_load);
  assign issue_last = (run_idx + 6'd1) == run_len;

  assign emit.busy  = run_active || rd_valid;
  assign emit.ready = !run_active && !rd_valid && !out_valid;

  // Payload starts after the five header bytes
  assign ram_re    = issue;
  assign ram_raddr = BUF_AW'({1'b0, run_idx} + HDR_BYTES);

  // Advance the run and the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (event_i.valid && event_i.status == ST_GOOD) begin
        run_active <= 1'b1;
      end else if (issue && issue_last) begin
        run_active <= 1'b0;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (event_i.valid && event_i.status == ST_GOOD) begin
      run_idx  <= '0;
      run_type <= event_i.ftype;
      run_len  <= event_i.len;
    end else if (issue) begin
      run_idx <= run_idx + 6'd1;
    end
    if (issue) begin
      rd_idx  <= run_idx;
      rd_last <= issue_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= rd_valid || (event_i.valid && event_i.status != ST_GOOD);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rd_valid) begin
        out_item.status <= ST_GOOD;
        out_item.ftype  <= run_type;
        out_item.len    <= run_len;
        out_item.idx    <= rd_idx;
        out_item.data   <= ram_rdata;
        out_item.last   <= rd_last;
      end else begin
        out_item.status <= event_i.status;
        out_item.ftype  <= event_i.ftype;
        out_item.len    <= event_i.len;
        out_item.idx    <= '0;
        out_item.data   <= '0;
        out_item.last   <= 1'b1;
      end
    end
  end

endmodule

/* design/serial_command_frame_receiver.sv */
// Channel  | Direction | Carries
// s_*      | in        | tdata: rx_byte[7:0]; tuser: req_type (1 = millisecond tick)
// m_*      | out       | tdata: frame_type, payload_len, payload_index, payload_byte;
//          |           | tuser: frame_status; tlast: last
// cfg_*    | in        | cfg_index selects the register, cfg_data the value
//
// One input item is taken per cycle. An error report is loaded into the output register
// from the frame's end byte; a good frame's first payload item follows the buffer read.
// A good frame's payload run leaves at one item per cycle from the frame buffer
// RAM (one read port); payload bytes of the next frame wait until the run is read.
// A frame's last byte waits until the output register is empty.
// Synchronous reset clears control state and loads register defaults; the frame
// buffer is not cleared. Stalls on m_tready hold the output item and back up input.
module serial_command_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] frame_type, [8:3] payload_len,
                                 // [14:9] payload_index, [22:15] payload_byte, [23] zero
  output logic [1:0]  m_tuser,   // [1:0] frame_status
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import scfr_pkg::*;

  frame_event_t      frame_event;
  emit_status_t      emit;
  result_t           result;
  logic              ram_we;
  logic [BUF_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [BUF_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Registers always take a write
  assign cfg_ready = 1'b1;

  scfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .emit      (emit),
    .event_o   (frame_event),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  scfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scfr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .event_i   (frame_event),
    .emit      (emit),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (result)
  );

  // Pack the result item
  assign m_tdata = {1'b0, result.data, result.idx, result.len, result.ftype};
  assign m_tuser = result.status;
  assign m_tlast = result.last;

endmodule

/* design/scfr_checker.sv */
module scfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import scfr_pkg::*;

  // Stalled output item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // Error reports are single items with no payload
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_GOOD |-> m_tlast && m_tdata[22:9] == 14'd0)
    else $error("error report malformed");

  // Payload index stays inside the frame length
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_GOOD |-> m_tdata[14:9] < m_tdata[8:3])
    else $error("payload index beyond length");

  // Last marks the final payload byte
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_GOOD |-> m_tlast == ((m_tdata[14:9] + 6'd1) == m_tdata[8:3]))
    else $error("last flag misplaced in run");

  // Consecutive payload items of one run count up by one
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == ST_GOOD && !m_tlast ##1 m_tvalid
      |-> m_tuser == ST_GOOD && m_tdata[14:9] == $past(m_tdata[14:9]) + 6'd1)
    else $error("payload run out of order");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
